@@ hw/rtl/vfib_pkg.sv @@
// Shared types and constants for the vehicle footprint bounds test.
package vfib_pkg;

    // CORDIC geometry: Q30 vectors, 32-bit binary angles carried in 33 bits.
    localparam int CORDIC_STEPS = 24;
    localparam int VEC_W        = 34;
    localparam int ANG_W        = 33;
    localparam int TRIG_W       = 18;
    localparam int POS_W        = 24;
    localparam int DIFF_W       = 25;
    localparam int WIDE_W       = 48;

    localparam logic signed [VEC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    // Arctangent of 2^-i as a fraction of a full turn, 2^32 per turn.
    localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_ORIGIN_X       = 3'd0,
        REG_ORIGIN_Y       = 3'd1,
        REG_ORIGIN_HEADING = 3'd2,
        REG_X_LOWER        = 3'd3,
        REG_X_UPPER        = 3'd4,
        REG_Y_LOWER        = 3'd5,
        REG_Y_UPPER        = 3'd6
    } cfg_reg_t;

    // Map area bounds handed to the footprint stages.
    typedef struct packed {
        logic signed [POS_W-1:0] x_lower;
        logic signed [POS_W-1:0] x_upper;
        logic signed [POS_W-1:0] y_lower;
        logic signed [POS_W-1:0] y_upper;
    } bounds_t;

endpackage

@@ hw/rtl/vfib_cordic.sv @@
// Pipelined rotation-mode CORDIC giving Q16 cosine and sine of a 16-bit angle.
module vfib_cordic import vfib_pkg::*; (
    input  logic                     aclk,
    input  logic                     ce,
    input  logic [15:0]              angle,
    output logic signed [TRIG_W-1:0] cos_out,
    output logic signed [TRIG_W-1:0] sin_out
);

    logic signed [VEC_W-1:0] x_reg [CORDIC_STEPS];
    logic signed [VEC_W-1:0] y_reg [CORDIC_STEPS];
    logic signed [ANG_W-1:0] z_reg [CORDIC_STEPS];
    logic                    flip_reg [CORDIC_STEPS];
    logic signed [ANG_W-1:0] z_in;
    logic signed [ANG_W-1:0] z_red;
    logic                    flip_in;
    logic signed [TRIG_W-1:0] cos_reg;
    logic signed [TRIG_W-1:0] sin_reg;
    logic signed [VEC_W-1:0] x_fin;
    logic signed [VEC_W-1:0] y_fin;
    logic signed [VEC_W-1:0] x_rnd;
    logic signed [VEC_W-1:0] y_rnd;
    logic signed [TRIG_W-1:0] cos_next;
    logic signed [TRIG_W-1:0] sin_next;

    // Fold angles beyond a quarter turn by a half turn; the result is negated later.
    always_comb begin
        z_in    = ANG_W'(signed'({angle, 16'b0}));
        z_red   = z_in;
        flip_in = 1'b0;
        if (z_in > 33'sd1073741824) begin
            z_red   = z_in - 33'sd2147483648;
            flip_in = 1'b1;
        end else if (z_in < -33'sd1073741824) begin
            z_red   = z_in + 33'sd2147483648;
            flip_in = 1'b1;
        end
    end

    // One micro-rotation per stage.
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic signed [VEC_W-1:0] x_prev;
        logic signed [VEC_W-1:0] y_prev;
        logic signed [ANG_W-1:0] z_prev;
        logic                    f_prev;
        if (i == 0) begin : g_first
            assign x_prev = CORDIC_GAIN_Q30;
            assign y_prev = '0;
            assign z_prev = z_red;
            assign f_prev = flip_in;
        end else begin : g_rest
            assign x_prev = x_reg[i-1];
            assign y_prev = y_reg[i-1];
            assign z_prev = z_reg[i-1];
            assign f_prev = flip_reg[i-1];
        end
        always_ff @(posedge aclk) begin
            if (ce) begin
                if (!z_prev[ANG_W-1]) begin
                    x_reg[i] <= x_prev - (y_prev >>> i);
                    y_reg[i] <= y_prev + (x_prev >>> i);
                    z_reg[i] <= z_prev - ANG_W'(signed'({1'b0, ATAN_TURN[i]}));
                end else begin
                    x_reg[i] <= x_prev + (y_prev >>> i);
                    y_reg[i] <= y_prev - (x_prev >>> i);
                    z_reg[i] <= z_prev + ANG_W'(signed'({1'b0, ATAN_TURN[i]}));
                end
                flip_reg[i] <= f_prev;
            end
        end
    end

    // Undo the fold, round Q30 to Q16 and clamp to plus or minus one.
    always_comb begin
        x_fin = flip_reg[CORDIC_STEPS-1] ? -x_reg[CORDIC_STEPS-1] : x_reg[CORDIC_STEPS-1];
        y_fin = flip_reg[CORDIC_STEPS-1] ? -y_reg[CORDIC_STEPS-1] : y_reg[CORDIC_STEPS-1];
        x_rnd = (x_fin + 34'sd8192) >>> 14;
        y_rnd = (y_fin + 34'sd8192) >>> 14;
        if (x_rnd > 34'sd65536) begin
            cos_next = 18'sd65536;
        end else if (x_rnd < -34'sd65536) begin
            cos_next = -18'sd65536;
        end else begin
            cos_next = x_rnd[TRIG_W-1:0];
        end
        if (y_rnd > 34'sd65536) begin
            sin_next = 18'sd65536;
        end else if (y_rnd < -34'sd65536) begin
            sin_next = -18'sd65536;
        end else begin
            sin_next = y_rnd[TRIG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign cos_out = cos_reg;
    assign sin_out = sin_reg;

endmodule

@@ hw/rtl/vfib_footprint.sv @@
// Four-stage map transform, corner construction and bounds compare.
module vfib_footprint import vfib_pkg::*; #(
    parameter int REAR_OVERHANG = 256,
    parameter int BODY_WIDTH    = 461,
    parameter int BODY_LENGTH   = 1152
) (
    input  logic                     aclk,
    input  logic                     ce,
    input  logic signed [DIFF_W-1:0] dx,
    input  logic signed [DIFF_W-1:0] dy,
    input  logic signed [TRIG_W-1:0] c0,
    input  logic signed [TRIG_W-1:0] s0,
    input  logic signed [TRIG_W-1:0] cv,
    input  logic signed [TRIG_W-1:0] sv,
    input  bounds_t                  bounds,
    output logic                     in_box
);

    localparam int KW = 16;
    localparam int PW = DIFF_W + TRIG_W;
    localparam int CW = KW + TRIG_W;
    localparam logic signed [KW-1:0] K_D2 = KW'(2 * REAR_OVERHANG);
    localparam logic signed [KW-1:0] K_W  = KW'(BODY_WIDTH);
    localparam logic signed [KW-1:0] K_W2 = KW'(2 * BODY_WIDTH);
    localparam logic signed [KW-1:0] K_L2 = KW'(2 * BODY_LENGTH);

    logic signed [PW-1:0] xc_reg, ys_reg, yc_reg, xs_reg;
    logic signed [CW-1:0] d2cv_reg, d2sv_reg, wsv_reg, wcv_reg;
    logic signed [CW-1:0] w2sv_reg, w2cv_reg, l2cv_reg, l2sv_reg;
    logic signed [CW-1:0] w2sv_s2_reg, w2cv_s2_reg, l2cv_s2_reg, l2sv_s2_reg;
    logic signed [WIDE_W-1:0] xa_reg, ya_reg;
    logic signed [WIDE_W-1:0] xa_next, ya_next;
    logic signed [WIDE_W-1:0] cx_reg [4];
    logic signed [WIDE_W-1:0] cy_reg [4];
    logic signed [WIDE_W-1:0] xlo, xhi, ylo, yhi;
    logic [3:0]               corner_ok;
    logic                     in_box_reg;

    // Stage 1: rotation products and scaled footprint offsets.
    always_ff @(posedge aclk) begin
        if (ce) begin
            xc_reg   <= PW'(dx) * PW'(c0);
            ys_reg   <= PW'(dy) * PW'(s0);
            yc_reg   <= PW'(dy) * PW'(c0);
            xs_reg   <= PW'(dx) * PW'(s0);
            d2cv_reg <= CW'(K_D2) * CW'(cv);
            d2sv_reg <= CW'(K_D2) * CW'(sv);
            wsv_reg  <= CW'(K_W) * CW'(sv);
            wcv_reg  <= CW'(K_W) * CW'(cv);
            w2sv_reg <= CW'(K_W2) * CW'(sv);
            w2cv_reg <= CW'(K_W2) * CW'(cv);
            l2cv_reg <= CW'(K_L2) * CW'(cv);
            l2sv_reg <= CW'(K_L2) * CW'(sv);
        end
    end

    // Stage 2: first corner at Q17.
    always_comb begin
        xa_next = ((WIDE_W'(xc_reg) + WIDE_W'(ys_reg)) <<< 1)
                  - WIDE_W'(d2cv_reg) - WIDE_W'(wsv_reg);
        ya_next = ((WIDE_W'(yc_reg) - WIDE_W'(xs_reg)) <<< 1)
                  - WIDE_W'(d2sv_reg) + WIDE_W'(wcv_reg);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            xa_reg      <= xa_next;
            ya_reg      <= ya_next;
            w2sv_s2_reg <= w2sv_reg;
            w2cv_s2_reg <= w2cv_reg;
            l2cv_s2_reg <= l2cv_reg;
            l2sv_s2_reg <= l2sv_reg;
        end
    end

    // Stage 3: remaining corners by offsets from the first.
    always_ff @(posedge aclk) begin
        if (ce) begin
            cx_reg[0] <= xa_reg;
            cy_reg[0] <= ya_reg;
            cx_reg[1] <= xa_reg + WIDE_W'(w2sv_s2_reg);
            cy_reg[1] <= ya_reg - WIDE_W'(w2cv_s2_reg);
            cx_reg[2] <= xa_reg + WIDE_W'(w2sv_s2_reg) + WIDE_W'(l2cv_s2_reg);
            cy_reg[2] <= ya_reg - WIDE_W'(w2cv_s2_reg) + WIDE_W'(l2sv_s2_reg);
            cx_reg[3] <= xa_reg + WIDE_W'(l2cv_s2_reg);
            cy_reg[3] <= ya_reg + WIDE_W'(l2sv_s2_reg);
        end
    end

    // Stage 4: strict compare of every corner against the bounds at Q17.
    always_comb begin
        xlo = WIDE_W'(bounds.x_lower) <<< 17;
        xhi = WIDE_W'(bounds.x_upper) <<< 17;
        ylo = WIDE_W'(bounds.y_lower) <<< 17;
        yhi = WIDE_W'(bounds.y_upper) <<< 17;
        for (int k = 0; k < 4; k++) begin
            corner_ok[k] = (cx_reg[k] > xlo) && (cx_reg[k] < xhi)
                        && (cy_reg[k] > ylo) && (cy_reg[k] < yhi);
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            in_box_reg <= &corner_ok;
        end
    end

    assign in_box = in_box_reg;

endmodule

@@ hw/rtl/vehicle_footprint_in_bounds.sv @@
// Top level of the vehicle footprint in-bounds test.
// Each accepted pose produces one inside_res flag, set when all four corners of
// the vehicle rectangle lie strictly inside the configured map bounds. The block
// is a 30-stage pipeline: one input register, a 24-step CORDIC with a rounding
// stage (run for both the origin heading and the relative heading), and four
// stages of multiply, corner construction and compare. A new transaction is
// accepted every cycle while the output is drained. The whole pipeline holds
// when a result waits on m_ready. Configuration writes take effect at once;
// the user must make them only while no transaction is in flight (unenforced).
module vehicle_footprint_in_bounds import vfib_pkg::*; #(
    parameter int REAR_OVERHANG = 256,
    parameter int BODY_WIDTH    = 461,
    parameter int BODY_LENGTH   = 1152
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [2:0]              cfg_index,
    input  logic [POS_W-1:0]        cfg_wdata,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [POS_W-1:0] s_pose_x,
    input  logic signed [POS_W-1:0] s_pose_y,
    input  logic [15:0]             s_pose_heading,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_inside_res
);

    localparam int TRIG_LAT = CORDIC_STEPS + 1;
    localparam int TOT_LAT  = 1 + TRIG_LAT + 4;

    logic signed [POS_W-1:0] origin_x_reg, origin_y_reg;
    logic [15:0]             origin_heading_reg;
    bounds_t                 bounds_reg;
    logic                    ce;
    logic [TOT_LAT-1:0]      vld_reg;
    logic signed [DIFF_W-1:0] dx_reg [TRIG_LAT+1];
    logic signed [DIFF_W-1:0] dy_reg [TRIG_LAT+1];
    logic [15:0]             rel_ang_reg, org_ang_reg;
    logic signed [TRIG_W-1:0] c0, s0, cv, sv;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg       <= '0;
            origin_y_reg       <= '0;
            origin_heading_reg <= '0;
            bounds_reg         <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_ORIGIN_X:       origin_x_reg       <= cfg_wdata;
                REG_ORIGIN_Y:       origin_y_reg       <= cfg_wdata;
                REG_ORIGIN_HEADING: origin_heading_reg <= cfg_wdata[15:0];
                REG_X_LOWER:        bounds_reg.x_lower <= cfg_wdata;
                REG_X_UPPER:        bounds_reg.x_upper <= cfg_wdata;
                REG_Y_LOWER:        bounds_reg.y_lower <= cfg_wdata;
                REG_Y_UPPER:        bounds_reg.y_upper <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // The pipeline advances whenever the output register is free or being taken.
    assign ce      = !vld_reg[TOT_LAT-1] || m_ready;
    assign s_ready = ce;

    // Valid bits travel alongside the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[TOT_LAT-2:0], s_valid};
        end
    end

    // Input stage: offsets from the origin and the relative heading.
    always_ff @(posedge aclk) begin
        if (ce) begin
            dx_reg[0]   <= DIFF_W'(s_pose_x) - DIFF_W'(origin_x_reg);
            dy_reg[0]   <= DIFF_W'(s_pose_y) - DIFF_W'(origin_y_reg);
            rel_ang_reg <= s_pose_heading - origin_heading_reg;
            org_ang_reg <= origin_heading_reg;
        end
    end

    // Offsets wait for the trigonometry.
    for (genvar i = 1; i <= TRIG_LAT; i++) begin : g_delay
        always_ff @(posedge aclk) begin
            if (ce) begin
                dx_reg[i] <= dx_reg[i-1];
                dy_reg[i] <= dy_reg[i-1];
            end
        end
    end

    vfib_cordic u_cordic_org (
        .aclk    (aclk),
        .ce      (ce),
        .angle   (org_ang_reg),
        .cos_out (c0),
        .sin_out (s0)
    );

    vfib_cordic u_cordic_rel (
        .aclk    (aclk),
        .ce      (ce),
        .angle   (rel_ang_reg),
        .cos_out (cv),
        .sin_out (sv)
    );

    vfib_footprint #(
        .REAR_OVERHANG (REAR_OVERHANG),
        .BODY_WIDTH    (BODY_WIDTH),
        .BODY_LENGTH   (BODY_LENGTH)
    ) u_footprint (
        .aclk   (aclk),
        .ce     (ce),
        .dx     (dx_reg[TRIG_LAT]),
        .dy     (dy_reg[TRIG_LAT]),
        .c0     (c0),
        .s0     (s0),
        .cv     (cv),
        .sv     (sv),
        .bounds (bounds_reg),
        .in_box (m_inside_res)
    );

    assign m_valid = vld_reg[TOT_LAT-1];

endmodule
